[src/pru_pkg.sv]
// Shared types, constants and codes of the pixel replicating upscaler.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package pru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_SCALE  = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PAD_ALIGN  = 4;

    localparam int SCALE_W = 5;
    localparam int WIDTH_W = 11;
    localparam int PIX_W   = 24;
    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int S_W     = $clog2(MAX_SCALE + 1);
    localparam int PASS_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int TOT_W   = $clog2(MAX_SCALE + PAD_ALIGN);
    localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic OP_NEW    = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    localparam logic [1:0] KIND_PIX = 2'd0;
    localparam logic [1:0] KIND_PAD = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PIX_W-1:0] out_value;
        logic             row_end;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [WIDTH_W-1:0] row_width;
    } t_cfg;

    typedef struct packed {
        logic             err;
        logic [PIX_W-1:0] pix;
        logic [S_W-1:0]   s;
        logic [TOT_W-1:0] total;
        logic             row_done;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic afull;
    } t_fifo_stat;

endpackage
`default_nettype wire

[src/pru_front.sv]
// Front end: accepts items, checks their kind, keeps the line store and row state,
// and issues one command per item. Depends on pru_pkg.
`default_nettype none
module pru_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pru_pkg::t_cfg        i_cfg,
    input  wire                  i_push,
    input  pru_pkg::t_in_item    i_item,
    input  pru_pkg::t_fifo_stat  i_fifo_stat,
    output logic                 o_full,
    output logic                 o_cmd_valid,
    output pru_pkg::t_cmd        o_cmd
);
    import pru_pkg::*;

    logic [PIX_W-1:0] line_store [MAX_WIDTH];

    logic [COL_W-1:0]  r_col, n_col;
    logic [PASS_W-1:0] r_passes, n_passes;
    logic              r_replaying, n_replaying;

    logic              r_v2;
    logic              r_err2;
    logic              r_new2;
    logic [PIX_W-1:0]  r_pix2;
    logic [PIX_W-1:0]  r_rd2;
    logic [S_W-1:0]    r_s2;
    logic [TOT_W-1:0]  r_tot2;
    logic              r_rdone2;

    logic                     acc;
    logic                     err;
    logic [S_W-1:0]           eff_s;
    logic [WIDTH_W-1:0]       eff_w;
    logic                     row_done;
    logic [WIDTH_W+S_W-1:0]   prod;
    logic [TOT_W-1:0]         pad;
    logic [PASS_W-1:0]        dec_passes;

    assign o_full = i_fifo_stat.full || (i_fifo_stat.afull && r_v2);
    assign acc    = i_push && !o_full;
    assign err    = (i_item.opcode == OP_REPLAY) != r_replaying;

    always_comb begin
        if (i_cfg.scale == '0) begin
            eff_s = S_W'(1);
        end else if (int'(i_cfg.scale) > MAX_SCALE) begin
            eff_s = S_W'(MAX_SCALE);
        end else begin
            eff_s = S_W'(i_cfg.scale);
        end
        if (i_cfg.row_width == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (int'(i_cfg.row_width) > MAX_WIDTH) begin
            eff_w = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_w = i_cfg.row_width;
        end
    end

    assign row_done   = (WIDTH_W'(r_col) + WIDTH_W'(1)) >= eff_w;
    assign prod       = WIDTH_W'(eff_w) * S_W'(eff_s);
    assign pad        = row_done ? TOT_W'(prod % PAD_ALIGN) : '0;
    assign dec_passes = (r_passes != '0) ? r_passes - PASS_W'(1) : '0;

    always_comb begin
        n_col       = r_col;
        n_passes    = r_passes;
        n_replaying = r_replaying;
        if (acc && !err) begin
            if (row_done) begin
                n_col = '0;
                if (!r_replaying) begin
                    if (eff_s > S_W'(1)) begin
                        n_passes    = PASS_W'(eff_s - S_W'(1));
                        n_replaying = 1'b1;
                    end
                end else begin
                    n_passes    = dec_passes;
                    n_replaying = (dec_passes != '0);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_passes    <= '0;
            r_replaying <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_passes    <= n_passes;
            r_replaying <= n_replaying;
            r_v2        <= acc;
        end
    end

    // Line store: write a new pixel, read the stored one for a replay.
    always_ff @(posedge i_clk) begin
        if (acc && !err && i_item.opcode == OP_NEW) begin
            line_store[r_col] <= i_item.pixel_value;
        end
        if (acc) begin
            r_rd2 <= line_store[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_err2   <= err;
            r_new2   <= (i_item.opcode == OP_NEW);
            r_pix2   <= i_item.pixel_value;
            r_s2     <= eff_s;
            r_tot2   <= TOT_W'(eff_s) + pad;
            r_rdone2 <= row_done;
        end
    end

    assign o_cmd_valid    = r_v2;
    assign o_cmd.err      = r_err2;
    assign o_cmd.pix      = r_new2 ? r_pix2 : r_rd2;
    assign o_cmd.s        = r_s2;
    assign o_cmd.total    = r_tot2;
    assign o_cmd.row_done = r_rdone2;

endmodule
`default_nettype wire

[src/pru_cmd_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on pru_pkg.
`default_nettype none
module pru_cmd_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  pru_pkg::t_cmd        i_cmd,
    input  wire                  i_pop,
    output pru_pkg::t_cmd        o_cmd,
    output pru_pkg::t_fifo_stat  o_stat
);
    import pru_pkg::*;

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign do_push = i_push;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= bump(r_wr);
            if (do_pop)  r_rd <= bump(r_rd);
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_stat.afull = (r_cnt >= CNT_W'(FIFO_DEPTH - 1));

endmodule
`default_nettype wire

[src/pru_back.sv]
// Back end: expands each command into its pixel copies, padding bytes or error
// result, one per cycle while pop does not stall it, into the output register. Depends on pru_pkg.
`default_nettype none
module pru_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pru_pkg::t_cmd        i_cmd,
    input  pru_pkg::t_fifo_stat  i_fifo_stat,
    output logic                 o_fifo_pop,
    input  wire                  i_pop,
    output logic                 o_empty,
    output pru_pkg::t_out_item   o_item
);
    import pru_pkg::*;

    t_cmd             r_cmd;
    logic             r_busy;
    logic [TOT_W-1:0] r_idx;
    t_out_item        r_out;
    logic             r_out_valid;

    logic      adv;
    logic      is_last;
    logic      load;
    t_out_item res;

    assign adv     = !r_out_valid || i_pop;
    assign is_last = r_cmd.err || (r_idx + TOT_W'(1) == r_cmd.total);
    assign load    = !i_fifo_stat.empty && (!r_busy || (adv && is_last));
    assign o_fifo_pop = load;

    always_comb begin
        res.last    = is_last;
        res.row_end = 1'b0;
        if (r_cmd.err) begin
            res.kind      = KIND_ERR;
            res.out_value = '0;
        end else if (TOT_W'(r_cmd.s) > r_idx) begin
            res.kind      = KIND_PIX;
            res.out_value = r_cmd.pix;
            res.row_end   = r_cmd.row_done && is_last;
        end else begin
            res.kind      = KIND_PAD;
            res.out_value = '0;
            res.row_end   = r_cmd.row_done && is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv && r_busy) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + TOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (adv && r_busy) begin
            r_out <= res;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule
`default_nettype wire

[src/pixel_replicating_upscaler_top.sv]
// Top level of the pixel replicating upscaler: configuration registers and
// the front end, command queue and back end. Depends on pru_pkg and all pru_ modules.
`default_nettype none
//
// Channel    Direction  Handshake                 Payload
// ---------  ---------  ------------------------  ---------------------------------
// input      in         push / full               i_in_item  (opcode, pixel_value)
// result     out        empty / pop               o_out_item (kind, out_value,
//                                                             row_end, last)
// config     in/out     psel, penable, pwrite,    paddr 0: scale, 4: row_width;
//                       pready (always high)      pwdata / prdata 32 bits
//
// Each item yields scale pixel copies, plus (row_width*scale) mod 4 padding bytes at
// a row end, or one error result; the back end emits one result per cycle while pop
// does not stall it, so an item takes scale + padding results (one for an error).
// An accepted item goes through the issue stage, the queue, the command and result registers.
// Reset is synchronous and active low; it clears the row state and the queue, and
// sets scale and row_width to 1. The line store has no reset.
// full rises when the command queue and the front end's issue stage hold four
// commands; a stalled pop holds the result register and backs up into the queue.
module pixel_replicating_upscaler_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pru_pkg::PADDR_W-1:0]   paddr,
    input  wire [pru_pkg::PDATA_W-1:0]   pwdata,
    output logic [pru_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // input requests
    input  wire                          push,
    output logic                         full,
    input  pru_pkg::t_in_item            i_in_item,
    // result requests
    output logic                         empty,
    input  wire                          pop,
    output pru_pkg::t_out_item           o_out_item
);
    import pru_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    logic [WIDTH_W-1:0] r_row_width;

    t_cfg       cfg;
    t_cmd       front_cmd;
    logic       front_valid;
    t_cmd       head_cmd;
    t_fifo_stat fifo_stat;
    logic       fifo_pop;
    logic       wr_en;

    // Register file: take a write on the access cycle, decode on address bit 2.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_W'(1);
            r_row_width <= WIDTH_W'(1);
        end else if (wr_en) begin
            case (paddr[2])
                REG_SCALE: r_scale     <= pwdata[SCALE_W-1:0];
                REG_WIDTH: r_row_width <= pwdata[WIDTH_W-1:0];
                default:   r_scale     <= r_scale;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SCALE: prdata = PDATA_W'(r_scale);
            REG_WIDTH: prdata = PDATA_W'(r_row_width);
            default:   prdata = '0;
        endcase
    end

    assign cfg.scale     = r_scale;
    assign cfg.row_width = r_row_width;

    // Front end: classify the request, update row state, issue a command.
    pru_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_fifo_stat (fifo_stat),
        .o_full      (full),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd)
    );

    // Command queue: decouple issue from expansion.
    pru_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .i_pop   (fifo_pop),
        .o_cmd   (head_cmd),
        .o_stat  (fifo_stat)
    );

    // Back end: expand each command into result requests.
    pru_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_fifo_stat (fifo_stat),
        .o_fifo_pop  (fifo_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule
`default_nettype wire

[dv/tb_pixel_replicating_upscaler_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pixel_replicating_upscaler_top: queued pixel and replay requests,
// an in-bench replication predictor, and a result checker on the pop side.
// Depends on pru_pkg and the upscaler RTL only.
module tb_pixel_replicating_upscaler_top;
    import pru_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_REQUESTS = 240;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WIDE_PIXELS     = 8;

    // Row position of the scan: column, replay passes still owed, replay mode.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [PASS_W-1:0] passes_left;
        logic              replaying;
    } t_scan_pos;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               push    = 1'b0;
    logic               full;
    t_in_item           i_in_item = '0;
    logic               empty;
    logic               pop     = 1'b0;
    t_out_item          o_out_item;

    pixel_replicating_upscaler_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    // Requests waiting to be pushed, and pixel/padding/error results still owed by the block.
    t_in_item  queued_requests[$];
    t_out_item predicted_results[$];

    // Predictor copy of the line buffer and row position; gen_pos shadows the
    // position as requests are generated so well-formed sequences can be built.
    logic [PIX_W-1:0]   line_pixels [MAX_WIDTH];
    t_scan_pos          pred_pos  = '0;
    t_scan_pos          gen_pos   = '0;
    logic [SCALE_W-1:0] scale_reg = SCALE_W'(1);
    logic [WIDTH_W-1:0] width_reg = WIDTH_W'(1);

    int   tx_idle_pct   = 0;
    int   rx_idle_pct   = 0;
    int   failures      = 0;
    int   cycle_count   = 0;
    int   issued        = 0;
    logic request_taken = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Out-of-range register values saturate into the legal range.
    function automatic int clamp_scale(logic [SCALE_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > MAX_SCALE) return MAX_SCALE;
        return int'(v);
    endfunction

    function automatic int clamp_width(logic [WIDTH_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > MAX_WIDTH) return MAX_WIDTH;
        return int'(v);
    endfunction

    // Step the scan by one well-formed request. A row ends on the first column at
    // or past the last column of the current width; a finished new-pixel row owes
    // scale-1 replay passes, and each finished replay row pays one back.
    function automatic t_scan_pos advance_row(t_scan_pos pos, int s, int w);
        t_scan_pos nxt;
        nxt = pos;
        if (int'(pos.col) + 1 >= w) begin
            nxt.col = '0;
            if (!pos.replaying) begin
                if (s > 1) begin
                    nxt.passes_left = PASS_W'(s - 1);
                    nxt.replaying   = 1'b1;
                end
            end else begin
                if (pos.passes_left != 0) nxt.passes_left = pos.passes_left - 1'b1;
                if (nxt.passes_left == 0) nxt.replaying = 1'b0;
            end
        end else begin
            nxt.col = pos.col + 1'b1;
        end
        return nxt;
    endfunction

    // Work out every result one accepted request causes and append them in order.
    task automatic predict_replicas(t_in_item req);
        int               s;
        int               w;
        int               pad;
        int               total;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] px;
        logic             done;
        t_out_item        res;
        s   = clamp_scale(scale_reg);
        w   = clamp_width(width_reg);
        col = pred_pos.col;
        // Wrong request kind: one error result, state untouched.
        if ((req.opcode == OP_REPLAY) != pred_pos.replaying) begin
            res.kind      = KIND_ERR;
            res.out_value = '0;
            res.row_end   = 1'b0;
            res.last      = 1'b1;
            predicted_results.push_back(res);
            return;
        end
        if (req.opcode == OP_NEW) begin
            line_pixels[col] = req.pixel_value;
            px = req.pixel_value;
        end else begin
            px = line_pixels[col];
        end
        done  = (int'(col) + 1 >= w);
        pad   = done ? (w * s) % PAD_ALIGN : 0;
        total = s + pad;
        for (int n = 0; n < total; n++) begin
            res.kind      = (n < s) ? KIND_PIX : KIND_PAD;
            res.out_value = (n < s) ? px : '0;
            res.last      = (n == total - 1);
            res.row_end   = done && res.last;
            predicted_results.push_back(res);
        end
        pred_pos = advance_row(pred_pos, s, w);
    endtask

    // Queue one request: the kind the scan expects when well_formed, else the other kind.
    task automatic queue_request(logic well_formed, logic [PIX_W-1:0] px);
        t_in_item req;
        req.opcode      = (gen_pos.replaying ~^ well_formed) ? OP_REPLAY : OP_NEW;
        req.pixel_value = px;
        queued_requests.push_back(req);
        if (well_formed)
            gen_pos = advance_row(gen_pos, clamp_scale(scale_reg), clamp_width(width_reg));
        issued++;
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic apb_write(logic idx, logic [PDATA_W-1:0] word);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both registers with junk in the unused upper bits; only call while idle.
    task automatic write_config(logic [SCALE_W-1:0] s, logic [WIDTH_W-1:0] w);
        logic [PDATA_W-1:0] word;
        word = $urandom();
        word[SCALE_W-1:0] = s;
        apb_write(REG_SCALE, word);
        scale_reg = s;
        word = $urandom();
        word[WIDTH_W-1:0] = w;
        apb_write(REG_WIDTH, word);
        width_reg = w;
        @(posedge i_clk);
    endtask

    // Hold until every queued request is taken and every owed result has been popped.
    task automatic wait_idle();
        while (queued_requests.size() != 0 || push || predicted_results.size() != 0)
            @(negedge i_clk);
    endtask

    // One random phase: pick a setting (extremes now and then), then a burst of
    // mostly well-formed requests with random pixels and a sprinkle of wrong kinds.
    task automatic random_phase();
        logic [SCALE_W-1:0] s;
        logic [WIDTH_W-1:0] w;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 6)       s = '0;
        else if (pick < 12) s = SCALE_W'(MAX_SCALE);
        else if (pick < 18) s = SCALE_W'($urandom_range(MAX_SCALE + 1, 31));
        else                s = SCALE_W'($urandom_range(1, 6));
        pick = $urandom_range(99);
        if (pick < 6)       w = '0;
        else if (pick < 14) w = WIDTH_W'($urandom_range(7, 12));
        else                w = WIDTH_W'($urandom_range(1, 6));
        // Never grow the row during replay passes: that would read unwritten columns.
        if (gen_pos.replaying && clamp_width(w) > clamp_width(width_reg)) w = width_reg;
        write_config(s, w);
        repeat ($urandom_range(12, 40))
            queue_request($urandom_range(99) < 90, PIX_W'($urandom()));
    endtask

    // Count a failure; report only the first few in full.
    function automatic void note_failure(string msg);
        failures++;
        if (failures <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
    endfunction

    // Stimulus sequencer: reset, directed phases, random phases, wide-register checks.
    initial begin
        int random_start;
        tx_idle_pct = 22;
        rx_idle_pct = 82;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unit scale and width: each pixel comes out once plus one pad byte;
        // extreme pixel values; replay while taking new pixels.
        write_config(SCALE_W'(1), WIDTH_W'(1));
        queue_request(1'b1, '0);
        queue_request(1'b1, '1);
        queue_request(1'b0, '1);
        wait_idle();

        // Scale 3 over a two-pixel row: error in each mode, then both replay passes.
        write_config(SCALE_W'(3), WIDTH_W'(2));
        queue_request(1'b1, PIX_W'(24'h123456));
        queue_request(1'b0, PIX_W'(24'h555555));
        queue_request(1'b1, PIX_W'(24'hFEDCBA));
        queue_request(1'b0, PIX_W'(24'hAAAAAA));
        repeat (4) queue_request(1'b1, PIX_W'($urandom()));
        wait_idle();

        // Zero in both registers acts as one.
        write_config('0, '0);
        queue_request(1'b1, PIX_W'(24'h800001));
        queue_request(1'b1, PIX_W'(24'h7FFFFE));
        queue_request(1'b0, '0);
        wait_idle();

        // Shrink the width mid-row: the next pixel closes the row early.
        write_config(SCALE_W'(2), WIDTH_W'(4));
        repeat (3) queue_request(1'b1, PIX_W'($urandom()));
        wait_idle();
        write_config(SCALE_W'(2), WIDTH_W'(2));
        repeat (3) queue_request(1'b1, PIX_W'($urandom()));
        wait_idle();

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        random_start = issued;
        while (issued < random_start + RANDOM_REQUESTS) begin
            if (issued < random_start + RANDOM_REQUESTS / 3) begin
                tx_idle_pct = 22;
                rx_idle_pct = 82;
            end else if (issued < random_start + 2 * RANDOM_REQUESTS / 3) begin
                tx_idle_pct = 82;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_phase();
            wait_idle();
        end

        // Finish any open row and replay passes so the wide row starts at column zero.
        while (gen_pos.replaying || gen_pos.col != 0)
            queue_request(1'b1, PIX_W'($urandom()));
        wait_idle();

        // Width register above the line buffer saturates to its full length: at scale 1
        // a run of pixels stays inside one row, at the top value and just past the limit.
        write_config(SCALE_W'(1), '1);
        repeat (WIDE_PIXELS) queue_request(1'b1, PIX_W'($urandom()));
        wait_idle();
        write_config(SCALE_W'(1), WIDTH_W'(MAX_WIDTH + 1));
        repeat (WIDE_PIXELS) queue_request(1'b1, PIX_W'($urandom()));
        wait_idle();

        // Scale register at its top value: sixteen copies, fifteen replay passes.
        write_config('1, WIDTH_W'(1));
        repeat (MAX_SCALE) queue_request(1'b1, PIX_W'($urandom()));
        queue_request(1'b0, PIX_W'($urandom()));
        wait_idle();

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Input side, edge half: note acceptance and predict the results it causes.
    always @(posedge i_clk) begin
        request_taken <= push && !full;
        if (push && !full) begin
            predict_replicas(i_in_item);
            void'(queued_requests.pop_front());
        end
    end

    // Input side, drive half: hold a pending request until taken, else advance
    // to the next one or idle with junk on the payload.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || request_taken) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                push      <= 1'b1;
                i_in_item <= queued_requests[0];
            end else begin
                push      <= 1'b0;
                i_in_item <= t_in_item'($bits(t_in_item)'($urandom()));
            end
        end
    end

    // Result side: drop pop at random to stall the block.
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each popped result against the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (pop && !empty) begin
            if (predicted_results.size() == 0) begin
                note_failure($sformatf("unexpected result kind %0d value %h row_end %b last %b",
                    o_out_item.kind, o_out_item.out_value, o_out_item.row_end,
                    o_out_item.last));
            end else begin
                want = predicted_results.pop_front();
                if (o_out_item.kind !== want.kind || o_out_item.out_value !== want.out_value ||
                    o_out_item.row_end !== want.row_end || o_out_item.last !== want.last) begin
                    note_failure({
                        $sformatf("result mismatch: got kind %0d value %h row_end %b last %b",
                            o_out_item.kind, o_out_item.out_value, o_out_item.row_end,
                            o_out_item.last),
                        $sformatf(", want kind %0d value %h row_end %b last %b",
                            want.kind, want.out_value, want.row_end, want.last)});
                end
            end
        end
    end

    // Watchdog: give up if the run stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
